[sv/plls_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// plls_pkg: shared types and constants of the least-laxity scheduler
// Task state layout, configuration bundle, register map and sequencer states.
// ----------------------------------------------------------------------------
package plls_pkg;

   // Task set size and timer widths
   localparam int MAX_TASKS = 4;
   localparam int TIME_W    = 16;
   localparam int FIELD_W   = 16;
   localparam int IDX_W     = 2;
   localparam int CNT_W     = 3;
   localparam int WORK_W    = TIME_W;
   localparam int TIMER_W   = 18;
   localparam int JOB_W     = 16;
   localparam int LAX_W     = TIMER_W + 1;
   localparam int PARAM_W   = 48;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;

   localparam logic [TIMER_W-1:0] DL_MIN  = TIMER_W'(1 << (TIMER_W - 1));
   localparam logic [JOB_W-1:0]   JOB_MAX = {JOB_W{1'b1}};

   // Register map, one 64-bit slot per register
   typedef enum logic [2:0] {
      REG_TASK_COUNT = 3'd0,
      REG_TASK_ZERO  = 3'd1,
      REG_TASK_ONE   = 3'd2,
      REG_TASK_TWO   = 3'd3,
      REG_TASK_THREE = 3'd4
   } csr_reg_type;

   // Configuration as seen by the scheduler core
   typedef struct packed {
      logic [CNT_W-1:0]                  task_count;
      logic [MAX_TASKS-1:0][PARAM_W-1:0] params;
   } cfg_type;

   // One task's state word; timers are two's complement
   typedef struct packed {
      logic [WORK_W-1:0]  work;
      logic [TIMER_W-1:0] deadline;
      logic [TIMER_W-1:0] period;
      logic [JOB_W-1:0]   job;
   } task_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RELOAD,
      ST_SCAN,
      ST_UPDATE,
      ST_DONE
   } plls_state_type;

   // Build a freshly loaded task entry from its parameter word
   function automatic task_entry_type load_entry(input logic [PARAM_W-1:0] raw,
                                                 input logic [JOB_W-1:0]   job);
      task_entry_type e;
      e.work     = WORK_W'(raw[TIME_W-1:0]);
      e.period   = TIMER_W'(raw[FIELD_W +: TIME_W]);
      e.deadline = TIMER_W'(raw[2*FIELD_W +: TIME_W]);
      e.job      = job;
      return e;
   endfunction

endpackage
`default_nettype wire

[sv/plls_csr.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// plls_csr: configuration register file
// APB-style write/read access to the task count and four task parameter words.
// ----------------------------------------------------------------------------
module plls_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [plls_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [plls_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [plls_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                 pready,
   output plls_pkg::cfg_type                    cfg
);
   import plls_pkg::*;

   logic [CNT_W-1:0]                  task_count_ff, task_count_in;
   logic [MAX_TASKS-1:0][PARAM_W-1:0] params_ff, params_in;
   csr_reg_type                       reg_sel;
   logic                              wr_en;

   assign reg_sel = csr_reg_type'(paddr[CSR_ADDR_W-1:3]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   // Decode the write beat
   always_comb begin
      task_count_in = task_count_ff;
      params_in     = params_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_TASK_COUNT: task_count_in = pwdata[CNT_W-1:0];
            REG_TASK_ZERO:  params_in[0]  = pwdata[PARAM_W-1:0];
            REG_TASK_ONE:   params_in[1]  = pwdata[PARAM_W-1:0];
            REG_TASK_TWO:   params_in[2]  = pwdata[PARAM_W-1:0];
            REG_TASK_THREE: params_in[3]  = pwdata[PARAM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= CNT_W'(1);
         params_ff     <= '0;
      end else begin
         task_count_ff <= task_count_in;
         params_ff     <= params_in;
      end
   end

   // Read mux
   always_comb begin
      case (reg_sel)
         REG_TASK_COUNT: prdata = CSR_DATA_W'(task_count_ff);
         REG_TASK_ZERO:  prdata = CSR_DATA_W'(params_ff[0]);
         REG_TASK_ONE:   prdata = CSR_DATA_W'(params_ff[1]);
         REG_TASK_TWO:   prdata = CSR_DATA_W'(params_ff[2]);
         REG_TASK_THREE: prdata = CSR_DATA_W'(params_ff[3]);
         default:        prdata = '0;
      endcase
   end

   assign cfg.task_count = task_count_ff;
   assign cfg.params     = params_ff;

endmodule
`default_nettype wire

[sv/plls_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// plls_core: task state memory and scan/update sequencer
// A scan pass reads every task in use to find the least laxity, then an update
// pass reads, counts down and writes back each task, one per cycle.
// ----------------------------------------------------------------------------
module plls_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire plls_pkg::cfg_type              cfg,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_restart,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [plls_pkg::IDX_W-1:0]          rsp_chosen_task,
   output logic                                rsp_idle,
   output logic [plls_pkg::JOB_W-1:0]          rsp_chosen_job,
   output logic [plls_pkg::MAX_TASKS-1:0]      rsp_miss_mask
);
   import plls_pkg::*;

   // Task state memory with per-entry valid bits (unwritten entries read zero)
   task_entry_type         mem [MAX_TASKS];
   logic [MAX_TASKS-1:0]   valid_ff;
   task_entry_type         rd_data_ff;
   logic                   rd_ok_ff;

   plls_state_type         state_ff, state_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic                   rd_vld_ff, rd_last_ff;
   logic [IDX_W-1:0]       rd_tag_ff;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       chosen_ff, chosen_in;
   logic [LAX_W-1:0]       best_ff, best_in;
   logic [MAX_TASKS-1:0]   miss_ff, miss_in;
   logic [JOB_W-1:0]       job_ff, job_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]       rsp_task_ff;
   logic                   rsp_idle_ff;
   logic [JOB_W-1:0]       rsp_job_ff;
   logic [MAX_TASKS-1:0]   rsp_miss_ff;
   logic                   rsp_load;

   logic                   rd_en, we;
   logic [IDX_W-1:0]       rd_addr, wr_addr;
   task_entry_type         wr_data;

   logic [CNT_W-1:0]       act_cnt;
   task_entry_type         cur;
   logic [LAX_W-1:0]       lax;
   logic                   charge;
   logic [WORK_W-1:0]      work_dec;
   logic [TIMER_W-1:0]     dl_dec, per_dec;
   logic                   task_miss, expire;
   logic [JOB_W-1:0]       job_inc;
   task_entry_type         upd_entry;

   // Saturate the task count at the table size
   assign act_cnt = (cfg.task_count > CNT_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS)
                                                          : cfg.task_count;

   // Entry returned by the memory, zero where never written
   assign cur = rd_ok_ff ? rd_data_ff : '0;
   assign lax = {cur.deadline[TIMER_W-1], cur.deadline}
              - {{(LAX_W-WORK_W){1'b0}}, cur.work};

   // Per-task tick: charge, count down, flag a miss, reload on period expiry
   assign charge    = found_ff && (chosen_ff == rd_tag_ff);
   assign work_dec  = cur.work - WORK_W'(charge);
   assign dl_dec    = (cur.deadline == DL_MIN) ? cur.deadline
                                               : cur.deadline - TIMER_W'(1);
   assign per_dec   = cur.period - TIMER_W'(1);
   assign task_miss = (dl_dec[TIMER_W-1] || (dl_dec == '0)) && (work_dec != '0);
   assign expire    = per_dec[TIMER_W-1] || (per_dec == '0);
   assign job_inc   = (cur.job == JOB_MAX) ? cur.job : cur.job + JOB_W'(1);

   always_comb begin
      if (expire) begin
         upd_entry = load_entry(cfg.params[rd_tag_ff], job_inc);
      end else begin
         upd_entry.work     = work_dec;
         upd_entry.deadline = dl_dec;
         upd_entry.period   = per_dec;
         upd_entry.job      = cur.job;
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      chosen_in    = chosen_ff;
      best_in      = best_ff;
      miss_in      = miss_ff;
      job_in       = job_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff[IDX_W-1:0];
      we           = 1'b0;
      wr_addr      = rd_tag_ff;
      wr_data      = upd_entry;
      rsp_load     = 1'b0;
      req_ready    = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               idx_in   = '0;
               found_in = 1'b0;
               chosen_in = '0;
               best_in  = '0;
               miss_in  = '0;
               job_in   = '0;
               state_in = req_restart ? ST_RELOAD : ST_SCAN;
            end
         end
         ST_RELOAD: begin
            we      = 1'b1;
            wr_addr = idx_ff[IDX_W-1:0];
            wr_data = load_entry(cfg.params[idx_ff[IDX_W-1:0]], '0);
            idx_in  = idx_ff + CNT_W'(1);
            if (idx_ff == CNT_W'(MAX_TASKS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            if (idx_ff < act_cnt) begin
               rd_en  = 1'b1;
               idx_in = idx_ff + CNT_W'(1);
            end
            // keep the least laxity among tasks with work left
            if (rd_vld_ff && (cur.work != '0)
                && (!found_ff || ($signed(lax) < $signed(best_ff)))) begin
               found_in  = 1'b1;
               best_in   = lax;
               chosen_in = rd_tag_ff;
            end
            if (act_cnt == '0) begin
               state_in = ST_DONE;
            end else if (rd_vld_ff && rd_last_ff) begin
               idx_in   = '0;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (idx_ff < act_cnt) begin
               rd_en  = 1'b1;
               idx_in = idx_ff + CNT_W'(1);
            end
            if (rd_vld_ff) begin
               we      = 1'b1;
               miss_in = miss_ff | (MAX_TASKS'(task_miss) << rd_tag_ff);
               if (charge) begin
                  job_in = upd_entry.job;
               end
               if (rd_last_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rd_vld_ff    <= rd_en;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (we) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Working registers and read pipeline tags
   always_ff @(posedge clock) begin
      chosen_ff  <= chosen_in;
      best_ff    <= best_in;
      miss_ff    <= miss_in;
      job_ff     <= job_in;
      rd_tag_ff  <= rd_addr;
      rd_last_ff <= (idx_ff == act_cnt - CNT_W'(1));
   end

   // Memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_ok_ff   <= valid_ff[rd_addr];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_task_ff <= found_ff ? chosen_ff : '0;
         rsp_idle_ff <= !found_ff;
         rsp_job_ff  <= found_ff ? job_ff : '0;
         rsp_miss_ff <= miss_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_chosen_task = rsp_task_ff;
   assign rsp_idle        = rsp_idle_ff;
   assign rsp_chosen_job  = rsp_job_ff;
   assign rsp_miss_mask   = rsp_miss_ff;

   a_chosen_in_use: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && found_ff) |-> (CNT_W'(chosen_ff) < act_cnt))
      else $error("chosen task outside the tasks in use");

   a_no_rw_same_entry: assert property (@(posedge clock) disable iff (reset)
      (we && rd_en) |-> (wr_addr != rd_addr))
      else $error("read and write of the same task entry in one cycle");

   a_read_in_pass: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ST_SCAN || state_ff == ST_UPDATE))
      else $error("read data returned outside a scan or update pass");

   a_idle_result_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_idle_ff) |-> (rsp_task_ff == '0 && rsp_job_ff == '0))
      else $error("idle result carries a task or job number");

endmodule
`default_nettype wire

[sv/periodic_least_laxity_scheduler.sv]
`default_nettype none
// Tick beat: the result follows one memory read per task in use (N = 1..4) in the scan pass
// and again in the update pass; with no task in use the scan pass ends at once.
// Restart beat: the result follows one write per task entry.
// Acceptance: a new beat is taken only when idle, after the previous result is registered.
// Reset: synchronous, clears the task state (all zero), task_count to 1, params to 0.
// ----------------------------------------------------------------------------
// periodic_least_laxity_scheduler: top level
// Least-laxity-first tick scheduler for up to four periodic tasks.
// ----------------------------------------------------------------------------
module periodic_least_laxity_scheduler (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_restart,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [plls_pkg::IDX_W-1:0]           rsp_chosen_task,
   output logic                                 rsp_idle,
   output logic [plls_pkg::JOB_W-1:0]           rsp_chosen_job,
   output logic [plls_pkg::MAX_TASKS-1:0]       rsp_miss_mask,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [plls_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [plls_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [plls_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                 pready
);
   import plls_pkg::*;

   cfg_type cfg;

   // Configuration registers
   plls_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Scheduler core
   plls_core u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_chosen_task (rsp_chosen_task),
      .rsp_idle        (rsp_idle),
      .rsp_chosen_job  (rsp_chosen_job),
      .rsp_miss_mask   (rsp_miss_mask)
   );

endmodule
`default_nettype wire

[tb/plls_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plls_tb_pkg: tick scoreboard for the least-laxity scheduler
// Mirrors the scheduler's per-task state, works out the pick, job and miss
// mask for every accepted beat, and checks result beats in order.
// ----------------------------------------------------------------------------
package plls_tb_pkg;
   import plls_pkg::*;

   // One expected result beat
   typedef struct packed {
      logic [IDX_W-1:0]     chosen;
      logic                 idle;
      logic [JOB_W-1:0]     job;
      logic [MAX_TASKS-1:0] miss;
   } tick_result_type;

   localparam logic signed [TIMER_W-1:0] DL_FLOOR   = DL_MIN;
   localparam logic signed [TIMER_W-1:0] TIMER_ZERO = '0;
   localparam logic signed [TIMER_W-1:0] TIMER_ONE  = TIMER_W'(1);

   class llf_scoreboard;
      // configuration copy
      logic [CNT_W-1:0]          task_count;
      logic [PARAM_W-1:0]        params [MAX_TASKS];
      // per-task state copy
      logic [WORK_W-1:0]         work_left [MAX_TASKS];
      logic signed [TIMER_W-1:0] deadline_left [MAX_TASKS];
      logic signed [TIMER_W-1:0] period_left [MAX_TASKS];
      logic [JOB_W-1:0]          job_number [MAX_TASKS];

      tick_result_type expected_ticks[$];

      int errors;
      int beats;
      int restarts;
      int idle_ticks;
      int miss_ticks;
      int ceiling_picks;

      function new();
         task_count = CNT_W'(1);
         for (int i = 0; i < MAX_TASKS; i++) begin
            params[i]        = '0;
            work_left[i]     = '0;
            deadline_left[i] = '0;
            period_left[i]   = '0;
            job_number[i]    = '0;
         end
         errors        = 0;
         beats         = 0;
         restarts      = 0;
         idle_ticks    = 0;
         miss_ticks    = 0;
         ceiling_picks = 0;
      endfunction

      function void write_reg(csr_reg_type r, logic [CSR_DATA_W-1:0] value);
         if (r == REG_TASK_COUNT)
            task_count = value[CNT_W-1:0];
         else
            params[int'(r) - int'(REG_TASK_ZERO)] = value[PARAM_W-1:0];
      endfunction

      // Load work and timers of one task from its parameter word
      function void reload(int i);
         work_left[i]     = params[i][TIME_W-1:0];
         period_left[i]   = $signed({2'b00, params[i][FIELD_W +: TIME_W]});
         deadline_left[i] = $signed({2'b00, params[i][2*FIELD_W +: TIME_W]});
      endfunction

      // Advance the mirrored state by one accepted beat and queue its result
      function void note_beat(logic restart);
         tick_result_type res;
         int n;
         int best;
         int lax;
         bit found;
         res = '0;
         beats++;
         if (restart) begin
            for (int i = 0; i < MAX_TASKS; i++) begin
               reload(i);
               job_number[i] = '0;
            end
            res.idle = 1'b1;
            restarts++;
            expected_ticks.push_back(res);
            return;
         end
         n = (int'(task_count) > MAX_TASKS) ? MAX_TASKS : int'(task_count);
         found = 1'b0;
         best = 0;
         // pick least laxity among tasks with work; ties keep the lower index
         for (int i = 0; i < n; i++) begin
            if (work_left[i] != '0) begin
               lax = int'(deadline_left[i]) - int'(work_left[i]);
               if (!found || lax < best) begin
                  found = 1'b1;
                  best = lax;
                  res.chosen = IDX_W'(i);
               end
            end
         end
         if (found)
            work_left[res.chosen] = work_left[res.chosen] - WORK_W'(1);
         // count down timers, flag misses, reload expired periods
         for (int i = 0; i < n; i++) begin
            period_left[i] = period_left[i] - TIMER_ONE;
            if (deadline_left[i] > DL_FLOOR)
               deadline_left[i] = deadline_left[i] - TIMER_ONE;
            if (deadline_left[i] <= TIMER_ZERO && work_left[i] != '0)
               res.miss[i] = 1'b1;
            if (period_left[i] <= TIMER_ZERO) begin
               reload(i);
               if (job_number[i] != JOB_MAX)
                  job_number[i] = job_number[i] + JOB_W'(1);
            end
         end
         res.idle = !found;
         if (found) begin
            res.job = job_number[res.chosen];
            if (res.job == JOB_MAX)
               ceiling_picks++;
         end else begin
            res.chosen = '0;
            idle_ticks++;
         end
         if (res.miss != '0)
            miss_ticks++;
         expected_ticks.push_back(res);
      endfunction

      // Compare one result beat with the oldest expectation
      function void check_beat(logic [IDX_W-1:0] chosen, logic idle,
                               logic [JOB_W-1:0] job, logic [MAX_TASKS-1:0] miss);
         tick_result_type want;
         if (expected_ticks.size() == 0) begin
            $error("result beat arrived with no tick outstanding");
            errors++;
            return;
         end
         want = expected_ticks.pop_front();
         if (chosen !== want.chosen) begin
            $error("chosen_task: expected %0d, actual %0d", want.chosen, chosen);
            errors++;
         end
         if (idle !== want.idle) begin
            $error("idle: expected %0d, actual %0d", want.idle, idle);
            errors++;
         end
         if (job !== want.job) begin
            $error("chosen_job: expected %0d, actual %0d", want.job, job);
            errors++;
         end
         if (miss !== want.miss) begin
            $error("miss_mask: expected 0x%0h, actual 0x%0h", want.miss, miss);
            errors++;
         end
      endfunction

      function int outstanding();
         return expected_ticks.size();
      endfunction
   endclass

endpackage

[tb/periodic_least_laxity_scheduler_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_least_laxity_scheduler_tb: self-checking bench for the scheduler
// Drives restart and tick beats under random gaps and back-pressure, rewrites
// the task registers between phases, and checks every result beat against a
// mirrored copy of the task state.
// ----------------------------------------------------------------------------
module periodic_least_laxity_scheduler_tb;
   import plls_pkg::*;
   import plls_tb_pkg::*;

   localparam int CYCLE_LIMIT      = 2_000_000;
   localparam int PHASE_BEATS      = 115;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_restart;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [IDX_W-1:0]      rsp_chosen_task;
   logic                  rsp_idle;
   logic [JOB_W-1:0]      rsp_chosen_job;
   logic [MAX_TASKS-1:0]  rsp_miss_mask;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   llf_scoreboard board;
   int cycle_count     = 0;
   int hold_off_cycles = 0;
   int settings_loaded = 0;
   bit steady          = 1'b0;

   periodic_least_laxity_scheduler dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_chosen_task (rsp_chosen_task),
      .rsp_idle        (rsp_idle),
      .rsp_chosen_job  (rsp_chosen_job),
      .rsp_miss_mask   (rsp_miss_mask),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #4 clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Check every result beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_beat(rsp_chosen_task, rsp_idle, rsp_chosen_job, rsp_miss_mask);
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 88)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Receiver: random stalls, plus a long hold-off on request
   initial begin : rsp_side
      rsp_ready = 1'b0;
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end else if (steady || $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat (pick_gap() + 1) @(posedge clock);
         end
      end
   end

   function automatic logic [PARAM_W-1:0] pack_task(int exec_t, int period_t, int dead_t);
      return {FIELD_W'(dead_t), FIELD_W'(period_t), FIELD_W'(exec_t)};
   endfunction

   // Mostly short tasks, some fully random words, a few at the field extremes
   function automatic logic [PARAM_W-1:0] draw_params();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75)
         return pack_task($urandom_range(0, 5), $urandom_range(0, 14),
                          $urandom_range(0, 16));
      else if (r < 92)
         return PARAM_W'({$urandom, $urandom});
      return pack_task($urandom_range(0, 1) * 65535, $urandom_range(0, 1) * 65535,
                       $urandom_range(0, 1) * 65535);
   endfunction

   // Offer one beat and hold it until accepted; idle afterwards at random
   task automatic send_beat(input logic restart);
      int gap;
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      board.note_beat(restart);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid   <= 1'b0;
         req_restart <= 1'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every result beat has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Setup cycle, then access cycle until pready
   task automatic csr_write(input csr_reg_type r, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({r, 3'b000});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.write_reg(r, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Rewrite every register once the block has drained; junk in unused bits
   task automatic load_config(input logic [CNT_W-1:0] count,
                              input logic [MAX_TASKS-1:0][PARAM_W-1:0] cfg);
      wait_idle();
      csr_write(REG_TASK_COUNT, {32'($urandom), 29'($urandom), count});
      for (int i = 0; i < MAX_TASKS; i++)
         csr_write(csr_reg_type'(int'(REG_TASK_ZERO) + i), {16'($urandom), cfg[i]});
      settings_loaded++;
   endtask

   // Random settings, a restart, then mostly ticks with rare restarts
   task automatic run_phase(input int beats, input bit pressure);
      logic [MAX_TASKS-1:0][PARAM_W-1:0] cfg;
      logic [CNT_W-1:0] count;
      count = ($urandom_range(0, 99) < 85) ? CNT_W'($urandom_range(1, 4))
                                           : CNT_W'($urandom_range(0, 7));
      for (int i = 0; i < MAX_TASKS; i++)
         cfg[i] = draw_params();
      load_config(count, cfg);
      send_beat(1'b1);
      for (int k = 0; k < beats; k++) begin
         if (k % 30 == 0)
            steady = ($urandom_range(0, 3) == 0);
         if (pressure && k == 20)
            hold_off_cycles = 150;
         if (pressure && k == beats / 2)
            wait_idle();
         send_beat($urandom_range(0, 99) < 6);
      end
      steady = 1'b0;
   endtask

   initial begin : stimulus
      logic [MAX_TASKS-1:0][PARAM_W-1:0] cfg;
      board       = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_restart = 1'b0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: one task, all parameters zero
      send_beat(1'b0);
      send_beat(1'b1);
      send_beat(1'b0);

      // count above the task limit; full-scale task, tie between tasks one
      // and three, period of one, period and deadline of zero
      cfg[0] = pack_task(65535, 65535, 65535);
      cfg[1] = pack_task(2, 3, 1);
      cfg[2] = pack_task(3, 1, 5);
      cfg[3] = pack_task(1, 0, 0);
      load_config(CNT_W'(7), cfg);
      send_beat(1'b0);
      send_beat(1'b1);
      repeat (8) send_beat(1'b0);
      send_beat(1'b1);
      repeat (2) send_beat(1'b0);

      // no tasks in use
      load_config(CNT_W'(0), cfg);
      send_beat(1'b1);
      repeat (2) send_beat(1'b0);

      // two tasks, the rest left untouched
      cfg[0] = pack_task(3, 4, 3);
      cfg[1] = pack_task(1, 2, 1);
      load_config(CNT_W'(2), cfg);
      send_beat(1'b1);
      repeat (3) send_beat(1'b0);

      // all-ones settings, then all-zero settings
      load_config(CNT_W'(7), '1);
      send_beat(1'b1);
      repeat (40) send_beat($urandom_range(0, 99) < 6);
      load_config(CNT_W'(0), '0);
      send_beat(1'b1);
      repeat (30) send_beat($urandom_range(0, 99) < 6);

      // random settings; one phase with a long receiver hold-off
      for (int ph = 0; ph < 5; ph++)
         run_phase(PHASE_BEATS, ph == 1);

      wait_idle();
      repeat (16) @(posedge clock);
      $display("Run covered %0d beats (%0d restarts) over %0d register settings.",
               board.beats, board.restarts, settings_loaded);
      $display("It saw %0d idle ticks, %0d ticks with misses, %0d picks at the job ceiling.",
               board.idle_ticks, board.miss_ticks, board.ceiling_picks);
      if (board.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
